// ===== hdl/gtu_pkg.sv =====
// ----------------------------------------------------------------------------
// gtu_pkg
// Shared types, constants and codes for the GPS time to UTC conversion pipe.
// ----------------------------------------------------------------------------
package gtu_pkg;

  localparam int FRACTION_BITS = 20;
  localparam int TOW_W  = 40;
  localparam int WEEK_W = 13;
  localparam int UTC_W  = 41;
  localparam int X_W    = 43;   // signed width of t - delta
  localparam int E_W    = 64;   // signed width of the drift time span
  localparam int W_W    = 24;   // signed width of whole seconds in the window
  localparam int MOD_STEPS = 6; // quotient bits of |x| / day length

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [X_W-1:0] DAY_LEN   = X_W'(64'd86400 << FRACTION_BITS);
  localparam logic [X_W-1:0] HALF_DAY  = X_W'(64'd43200 << FRACTION_BITS);
  localparam logic [X_W-1:0] WINDOW    = X_W'(64'd21600 << FRACTION_BITS);
  localparam int             WEEK_SEC  = 604800;
  localparam int             DAY_SEC   = 86400;

  typedef enum logic [1:0] {
    RULE_BEFORE  = 2'd0,
    RULE_OUTSIDE = 2'd1,
    RULE_WINDOW  = 2'd2,
    RULE_PAST    = 2'd3
  } rule_t;

  typedef enum logic [2:0] {
    REG_BIAS_A0        = 3'd0,
    REG_DRIFT_A1       = 3'd1,
    REG_REFERENCE_TIME = 3'd2,
    REG_REFERENCE_WEEK = 3'd3,
    REG_LEAP_NOW       = 3'd4,
    REG_LEAP_WEEK      = 3'd5,
    REG_LEAP_DAY       = 3'd6,
    REG_LEAP_FUTURE    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] bias_a0;
    logic [23:0] drift_a1;
    logic [19:0] reference_time;
    logic [12:0] reference_week;
    logic [7:0]  leap_now;
    logic [12:0] leap_week;
    logic [2:0]  leap_day;
    logic [7:0]  leap_future;
  } cfg_t;

  typedef struct packed {
    logic [X_W-1:0]   x;     // signed t - delta (less half a day in the window)
    logic [TOW_W-1:0] tow;
    rule_t            rule;
  } off_t;

  typedef struct packed {
    logic             neg;
    logic [X_W-1:0]   mag;
    logic [TOW_W-1:0] tow_rem;
    logic [TOW_W-1:0] tow;
    rule_t            rule;
  } red_t;

endpackage

// ===== hdl/gtu_ifs.sv =====
// ----------------------------------------------------------------------------
// gtu_sample_if / gtu_result_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface gtu_sample_if;
  logic                       valid;
  logic                       ready;
  logic [gtu_pkg::TOW_W-1:0]  gps_time_of_week;
  logic [gtu_pkg::WEEK_W-1:0] gps_week;
  modport source (output valid, gps_time_of_week, gps_week, input ready);
  modport sink (input valid, gps_time_of_week, gps_week, output ready);
endinterface

interface gtu_result_if;
  logic                             valid;
  logic                             ready;
  logic signed [gtu_pkg::UTC_W-1:0] utc_time_of_week;
  logic [1:0]                       rule_used;
  modport source (output valid, utc_time_of_week, rule_used, input ready);
  modport sink (input valid, utc_time_of_week, rule_used, output ready);
endinterface

// ===== hdl/gps_time_to_utc_conversion.sv =====
// ----------------------------------------------------------------------------
// gps_time_to_utc_conversion
// GPS time of week and week number to UTC seconds of week, fixed point.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake           | word
//  ---------+-----+---------------------+----------------------------------
//  sample   | in  | valid/ready         | gps_time_of_week, gps_week
//  result   | out | valid/ready         | utc_time_of_week, rule_used
//  apb      | in  | psel/penable/pready | 8 registers at 4*index
//
//  One word enters per cycle unless back-pressure from the result stalls the
//  pipe; a word passes 14 register stages on its way to the output register
//  (4 offset stages, 7 reduction stages, 3 finish stages).
//  The depth is set by the day-length reduction, one quotient bit per stage.
//  Every stage has its own valid bit and loads when it is empty or its
//  successor loads, so a stalled result holds in place while bubbles upstream
//  keep filling. Synchronous reset clears valid bits and parameter registers.
// ----------------------------------------------------------------------------
module gps_time_to_utc_conversion (
  input  logic                       clk,
  input  logic                       rst,
  gtu_sample_if.sink                 sample,
  gtu_result_if.source               result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gtu_pkg::ADDR_W-1:0] paddr,
  input  logic [gtu_pkg::DATA_W-1:0] pwdata,
  output logic [gtu_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import gtu_pkg::*;

  cfg_t cfg;
  logic off_valid, off_ready;
  off_t off_data;
  logic red_valid, red_ready;
  red_t red_data;

  // The user must change parameters only with the pipe empty; not enforced.
  gtu_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pick the rule, form the drift span and offset, subtract from t.
  gtu_offset u_offset (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .tow_in    (sample.gps_time_of_week),
    .week_in   (sample.gps_week),
    .out_valid (off_valid),
    .out_ready (off_ready),
    .out_data  (off_data)
  );

  // Reduce t - delta and t by the day length (fmod semantics).
  gtu_modred u_modred (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (off_valid),
    .in_ready  (off_ready),
    .in_data   (off_data),
    .out_valid (red_valid),
    .out_ready (red_ready),
    .out_data  (red_data)
  );

  // Apply the window rule, add the day base, hold in the output register.
  gtu_finish u_finish (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .in_valid         (red_valid),
    .in_ready         (red_ready),
    .in_data          (red_data),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .utc_time_of_week (result.utc_time_of_week),
    .rule_used        (result.rule_used)
  );

endmodule

// ===== hdl/gtu_regs.sv =====
// ----------------------------------------------------------------------------
// gtu_regs
// APB register file holding the UTC parameters.
// ----------------------------------------------------------------------------
module gtu_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gtu_pkg::ADDR_W-1:0]  paddr,
  input  logic [gtu_pkg::DATA_W-1:0]  pwdata,
  output logic [gtu_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output gtu_pkg::cfg_t               cfg
);
  import gtu_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_BIAS_A0:        cfg.bias_a0        <= pwdata[31:0];
        REG_DRIFT_A1:       cfg.drift_a1       <= pwdata[23:0];
        REG_REFERENCE_TIME: cfg.reference_time <= pwdata[19:0];
        REG_REFERENCE_WEEK: cfg.reference_week <= pwdata[12:0];
        REG_LEAP_NOW:       cfg.leap_now       <= pwdata[7:0];
        REG_LEAP_WEEK:      cfg.leap_week      <= pwdata[12:0];
        REG_LEAP_DAY:       cfg.leap_day       <= pwdata[2:0];
        REG_LEAP_FUTURE:    cfg.leap_future    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BIAS_A0:        prdata = cfg.bias_a0;
      REG_DRIFT_A1:       prdata = {{8{cfg.drift_a1[23]}}, cfg.drift_a1};
      REG_REFERENCE_TIME: prdata = {12'd0, cfg.reference_time};
      REG_REFERENCE_WEEK: prdata = {19'd0, cfg.reference_week};
      REG_LEAP_NOW:       prdata = {{24{cfg.leap_now[7]}}, cfg.leap_now};
      REG_LEAP_WEEK:      prdata = {19'd0, cfg.leap_week};
      REG_LEAP_DAY:       prdata = {29'd0, cfg.leap_day};
      REG_LEAP_FUTURE:    prdata = {{24{cfg.leap_future[7]}}, cfg.leap_future};
      default:            prdata = '0;
    endcase
  end

endmodule

// ===== hdl/gtu_offset.sv =====
// ----------------------------------------------------------------------------
// gtu_offset
// Four-stage front end: rule and drift span, drift product, delta, t - delta.
// ----------------------------------------------------------------------------
module gtu_offset (
  input  logic                       clk,
  input  logic                       rst,
  input  gtu_pkg::cfg_t              cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [gtu_pkg::TOW_W-1:0]  tow_in,
  input  logic [gtu_pkg::WEEK_W-1:0] week_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output gtu_pkg::off_t              out_data
);
  import gtu_pkg::*;

  logic [3:0] v;
  logic [3:0] en;

  // stage 1
  logic signed [13:0]  dweek;
  logic signed [34:0]  week_span;
  logic signed [13:0]  weeks_to;
  logic signed [41:0]  off;
  logic signed [E_W-1:0] e_next;
  rule_t               rule_next;
  logic [TOW_W-1:0]    tow1;
  rule_t               rule1;
  logic signed [E_W-1:0] e1;
  // stage 2
  logic [TOW_W-1:0]    tow2;
  rule_t               rule2;
  logic signed [55:0]  prod_hi;
  logic signed [56:0]  prod_lo;
  // stage 3
  logic signed [87:0]  prod_sum;
  logic signed [X_W-1:0] delta_next;
  logic [7:0]          leap;
  logic [TOW_W-1:0]    tow3;
  rule_t               rule3;
  logic signed [X_W-1:0] delta3;
  // stage 4
  logic signed [X_W-1:0] x_next;

  assign en[3]    = !v[3] || out_ready;
  assign en[2]    = !v[2] || en[3];
  assign en[1]    = !v[1] || en[2];
  assign en[0]    = !v[0] || en[1];
  assign in_ready = en[0];
  assign out_valid = v[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
      if (en[3]) v[3] <= v[2];
    end
  end

  // Span since the reference time, and the rule from week and event day.
  always_comb begin
    dweek     = $signed({1'b0, week_in}) - $signed({1'b0, cfg.reference_week});
    week_span = dweek * $signed(35'(WEEK_SEC));
    e_next    = $signed(E_W'(tow_in)) - $signed(E_W'(cfg.reference_time) << FRACTION_BITS)
              + (E_W'(week_span) <<< FRACTION_BITS);
    weeks_to  = $signed({1'b0, cfg.leap_week}) - $signed({1'b0, week_in});
    off       = $signed(42'(tow_in)) - $signed(42'(cfg.leap_day) * 42'(DAY_LEN));
    if (weeks_to > 0) begin
      rule_next = RULE_BEFORE;
    end else if (weeks_to == 0) begin
      if (off > $signed(42'(WINDOW))) begin
        rule_next = RULE_PAST;
      end else if (off < -$signed(42'(WINDOW))) begin
        rule_next = RULE_OUTSIDE;
      end else begin
        rule_next = RULE_WINDOW;
      end
    end else begin
      rule_next = RULE_PAST;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      tow1  <= tow_in;
      rule1 <= rule_next;
      e1    <= e_next;
    end
  end

  // Split the drift product into two partial products.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      tow2    <= tow1;
      rule2   <= rule1;
      prod_hi <= $signed(cfg.drift_a1) * $signed(e1[63:32]);
      prod_lo <= $signed(cfg.drift_a1) * $signed({1'b0, e1[31:0]});
    end
  end

  assign prod_sum   = (88'(prod_hi) <<< 32) + 88'(prod_lo);
  assign leap       = (rule2 == RULE_PAST) ? cfg.leap_future : cfg.leap_now;
  assign delta_next = X_W'(prod_sum >>> 50)
                    + X_W'($signed(cfg.bias_a0) >>> (30 - FRACTION_BITS))
                    + (X_W'($signed(leap)) <<< FRACTION_BITS);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      tow3   <= tow2;
      rule3  <= rule2;
      delta3 <= delta_next;
    end
  end

  assign x_next = $signed(X_W'(tow3)) - delta3
                - ((rule3 == RULE_WINDOW) ? $signed(HALF_DAY) : $signed(X_W'(0)));

  always_ff @(posedge clk) begin
    if (en[3]) begin
      out_data.x    <= x_next;
      out_data.tow  <= tow3;
      out_data.rule <= rule3;
    end
  end

endmodule

// ===== hdl/gtu_modred.sv =====
// ----------------------------------------------------------------------------
// gtu_modred
// Truncating reduction by the day length: a magnitude stage, then one
// compare-subtract per stage, applied to t - delta and to t side by side.
// ----------------------------------------------------------------------------
module gtu_modred (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  gtu_pkg::off_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output gtu_pkg::red_t out_data
);
  import gtu_pkg::*;

  localparam int S = MOD_STEPS + 1;

  logic [S-1:0] v;
  logic [S-1:0] en;
  red_t         st [S];

  assign en[S-1]   = !v[S-1] || out_ready;
  assign en[0]     = !v[0] || en[1];
  assign in_ready  = en[0];
  assign out_valid = v[S-1];
  assign out_data  = st[S-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en[0]) begin
      v[0] <= in_valid;
    end
  end

  // Take the magnitude; the sign returns at the end.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      st[0].neg     <= in_data.x[X_W-1];
      st[0].mag     <= in_data.x[X_W-1] ? X_W'(-$signed(in_data.x)) : in_data.x;
      st[0].tow_rem <= in_data.tow;
      st[0].tow     <= in_data.tow;
      st[0].rule    <= in_data.rule;
    end
  end

  for (genvar k = 1; k < S; k++) begin : g_step
    localparam logic [X_W-1:0] STEP = DAY_LEN << (MOD_STEPS - k);

    if (k < S - 1) begin : g_en
      assign en[k] = !v[k] || en[k+1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        st[k].neg  <= st[k-1].neg;
        st[k].tow  <= st[k-1].tow;
        st[k].rule <= st[k-1].rule;
        st[k].mag  <= (st[k-1].mag >= STEP) ? st[k-1].mag - STEP : st[k-1].mag;
        st[k].tow_rem <= (X_W'(st[k-1].tow_rem) >= STEP)
                       ? TOW_W'(X_W'(st[k-1].tow_rem) - STEP) : st[k-1].tow_rem;
      end
    end
  end

endmodule

// ===== hdl/gtu_finish.sv =====
// ----------------------------------------------------------------------------
// gtu_finish
// Three-stage back end: signed remainder and day base, leap window seconds,
// final sum into the output register.
// ----------------------------------------------------------------------------
module gtu_finish (
  input  logic                              clk,
  input  logic                              rst,
  input  gtu_pkg::cfg_t                     cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  gtu_pkg::red_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [gtu_pkg::UTC_W-1:0]  utc_time_of_week,
  output logic [1:0]                        rule_used
);
  import gtu_pkg::*;

  logic [2:0] v;
  logic [2:0] en;

  logic signed [X_W-1:0] rem_a;
  logic [TOW_W-1:0]      base_a;
  rule_t                 rule_a;

  logic signed [X_W:0]   wf;
  logic [X_W:0]          wf_mag;
  logic [X_W:0]          w_mag;
  logic signed [W_W-1:0] w_next;
  logic signed [X_W-1:0] rem_b;
  logic [TOW_W-1:0]      base_b;
  rule_t                 rule_b;
  logic signed [W_W-1:0] w_b;

  logic signed [17:0]    m;
  logic signed [W_W-1:0] wm;
  logic signed [UTC_W-1:0] day;

  assign en[2]     = !v[2] || out_ready;
  assign en[1]     = !v[1] || en[2];
  assign en[0]     = !v[0] || en[1];
  assign in_ready  = en[0];
  assign out_valid = v[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_a  <= in_data.neg ? -$signed(in_data.mag) : $signed(in_data.mag);
      base_a <= in_data.tow - in_data.tow_rem;
      rule_a <= in_data.rule;
    end
  end

  // Whole seconds of the window day time, truncated toward zero.
  always_comb begin
    wf     = (X_W+1)'(rem_a) + $signed((X_W+1)'(HALF_DAY));
    wf_mag = wf[X_W] ? (X_W+1)'(-wf) : wf;
    w_mag  = wf_mag >> FRACTION_BITS;
    w_next = wf[X_W] ? -$signed(W_W'(w_mag)) : $signed(W_W'(w_mag));
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      rem_b  <= rem_a;
      base_b <= base_a;
      rule_b <= rule_a;
      w_b    <= w_next;
    end
  end

  always_comb begin
    m = 18'(DAY_SEC) + 18'($signed(cfg.leap_future)) - 18'($signed(cfg.leap_now));
    if (w_b >= W_W'(m)) begin
      wm = w_b - W_W'(m);
    end else if (w_b <= -W_W'(m)) begin
      wm = w_b + W_W'(m);
    end else begin
      wm = w_b;
    end
    day = (rule_b == RULE_WINDOW) ? (UTC_W'(wm) <<< FRACTION_BITS) : UTC_W'(rem_b);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      utc_time_of_week <= $signed(UTC_W'(base_b)) + day;
      rule_used        <= rule_b;
    end
  end

endmodule
